// ===== rtl/dht_lookup_message_router_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ring-lookup message router
// Two forms: a same-cycle implication and a next-cycle implication.
// ----------------------------------------------------------------------------
`ifndef DHT_LOOKUP_MESSAGE_ROUTER_UNIT_ASSERT_SVH
`define DHT_LOOKUP_MESSAGE_ROUTER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define DLMR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define DLMR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DLMR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define DLMR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/dlmr_pkg.sv =====
// ----------------------------------------------------------------------------
// dlmr_pkg
// Shared constants, types and the ring interval test of the lookup router.
// ----------------------------------------------------------------------------
`default_nettype none

package dlmr_pkg;

	localparam int CacheEntries = 8;
	localparam int IdxW = (CacheEntries > 1) ? $clog2(CacheEntries) : 1;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 32;

	typedef logic [IdxW-1:0] idx_t;
	typedef logic [CfgIdxW-1:0] cfg_idx_t;

	localparam cfg_idx_t RegOwnId = 3'd0;
	localparam cfg_idx_t RegPredId = 3'd1;
	localparam cfg_idx_t RegSuccId = 3'd2;
	localparam cfg_idx_t RegOwnIp = 3'd3;
	localparam cfg_idx_t RegOwnPort = 3'd4;
	localparam cfg_idx_t RegSuccIp = 3'd5;
	localparam cfg_idx_t RegSuccPort = 3'd6;

	localparam logic [7:0] KindLookup = 8'd0;
	localparam logic [7:0] KindReply = 8'd1;

	localparam logic [1:0] ActNone = 2'd0;
	localparam logic [1:0] ActReply = 2'd1;
	localparam logic [1:0] ActForward = 2'd2;

	typedef enum logic [2:0] {
		SEL_ZERO,
		SEL_OWN,
		SEL_SUCC,
		SEL_CACHE,
		SEL_FWD
	} sel_t;

	typedef struct packed {
		logic [15:0] pred;
		logic [15:0] owner;
		logic [31:0] addr;
		logic [15:0] port;
	} entry_t;

	typedef struct packed {
		logic capture;
		logic cache_wr;
		logic idx_clr;
		logic idx_inc;
		logic stage_load;
		sel_t sel;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic kind_lookup;
		logic kind_reply;
		logic own_hit;
		logic succ_hit;
		logic cache_hit;
		logic idx_last;
	} sts_t;

	function automatic logic covers(input logic [15:0] pred, input logic [15:0] owner,
			input logic [15:0] key);
		if (pred <= owner) begin
			return (key > pred) && (key <= owner);
		end
		return (key <= owner) || (key > pred);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/dlmr_datapath.sv =====
// ----------------------------------------------------------------------------
// dlmr_datapath
// Node registers, captured message, reply cache, scan index, result staging
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dlmr_datapath (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire dlmr_pkg::cfg_idx_t             cfg_index,
	input  wire logic [dlmr_pkg::CfgDataW-1:0]  cfg_data,
	input  wire logic [7:0]                     msg_kind,
	input  wire logic [15:0]                    key_id,
	input  wire logic [15:0]                    sender_id,
	input  wire logic [31:0]                    sender_ip,
	input  wire logic [15:0]                    sender_port,
	input  wire dlmr_pkg::cmd_t                 cmd,
	output dlmr_pkg::sts_t                      sts,
	output logic [1:0]                          action,
	output logic [31:0]                         dest_ip,
	output logic [15:0]                         dest_port,
	output logic [7:0]                          out_kind,
	output logic [15:0]                         out_key_id,
	output logic [15:0]                         out_node_id,
	output logic [31:0]                         out_node_ip,
	output logic [15:0]                         out_node_port
);

	logic [15:0] own_id_q, pred_id_q, succ_id_q, own_port_q, succ_port_q;
	logic [31:0] own_ip_q, succ_ip_q;

	logic [7:0]  kind_q;
	logic [15:0] key_q, sid_q, sport_q;
	logic [31:0] sip_q;

	dlmr_pkg::entry_t cache_mem [dlmr_pkg::CacheEntries];
	logic [dlmr_pkg::CacheEntries-1:0] valid_q;
	dlmr_pkg::idx_t slot_q, idx_q;
	dlmr_pkg::entry_t rd_q;
	logic rd_vld_q;

	logic [1:0]  stg_action_q;
	logic [31:0] stg_dip_q, stg_nip_q;
	logic [15:0] stg_dport_q, stg_key_q, stg_nid_q, stg_nport_q;
	logic [7:0]  stg_kind_q;

	logic [1:0]  nx_action;
	logic [31:0] nx_dip, nx_nip;
	logic [15:0] nx_dport, nx_key, nx_nid, nx_nport;
	logic [7:0]  nx_kind;

	// node registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q <= '0;
			pred_id_q <= '0;
			succ_id_q <= '0;
			own_ip_q <= '0;
			own_port_q <= '0;
			succ_ip_q <= '0;
			succ_port_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				dlmr_pkg::RegOwnId:    own_id_q <= cfg_data[15:0];
				dlmr_pkg::RegPredId:   pred_id_q <= cfg_data[15:0];
				dlmr_pkg::RegSuccId:   succ_id_q <= cfg_data[15:0];
				dlmr_pkg::RegOwnIp:    own_ip_q <= cfg_data[31:0];
				dlmr_pkg::RegOwnPort:  own_port_q <= cfg_data[15:0];
				dlmr_pkg::RegSuccIp:   succ_ip_q <= cfg_data[31:0];
				dlmr_pkg::RegSuccPort: succ_port_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// captured message
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= msg_kind;
			key_q <= key_id;
			sid_q <= sender_id;
			sip_q <= sender_ip;
			sport_q <= sender_port;
		end
	end

	// cache control: valid bits, round-robin slot, scan index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			slot_q <= '0;
			idx_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= valid_q[idx_q];
			if (cmd.cache_wr) begin
				valid_q[slot_q] <= 1'b1;
				slot_q <= (slot_q == dlmr_pkg::idx_t'(dlmr_pkg::CacheEntries - 1)) ?
					'0 : slot_q + 1'b1;
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// cache storage
	always_ff @(posedge clk) begin
		if (cmd.cache_wr) begin
			cache_mem[slot_q] <= '{pred: key_q, owner: sid_q, addr: sip_q, port: sport_q};
		end
		rd_q <= cache_mem[idx_q];
	end

	assign sts.kind_lookup = (kind_q == dlmr_pkg::KindLookup);
	assign sts.kind_reply = (kind_q == dlmr_pkg::KindReply);
	assign sts.own_hit = ((pred_id_q == succ_id_q) && (own_id_q == pred_id_q)) ||
		dlmr_pkg::covers(pred_id_q, own_id_q, key_q);
	assign sts.succ_hit = dlmr_pkg::covers(own_id_q, succ_id_q, key_q);
	assign sts.cache_hit = rd_vld_q && dlmr_pkg::covers(rd_q.pred, rd_q.owner, key_q);
	assign sts.idx_last = (idx_q == dlmr_pkg::idx_t'(dlmr_pkg::CacheEntries - 1));

	// result selection
	always_comb begin
		nx_action = dlmr_pkg::ActReply;
		nx_dip = sip_q;
		nx_dport = sport_q;
		nx_kind = dlmr_pkg::KindReply;
		nx_key = '0;
		nx_nid = '0;
		nx_nip = '0;
		nx_nport = '0;
		case (cmd.sel)
			dlmr_pkg::SEL_OWN: begin
				nx_key = pred_id_q;
				nx_nid = own_id_q;
				nx_nip = own_ip_q;
				nx_nport = own_port_q;
			end
			dlmr_pkg::SEL_SUCC: begin
				nx_key = own_id_q;
				nx_nid = succ_id_q;
				nx_nip = succ_ip_q;
				nx_nport = succ_port_q;
			end
			dlmr_pkg::SEL_CACHE: begin
				nx_key = rd_q.pred;
				nx_nid = rd_q.owner;
				nx_nip = rd_q.addr;
				nx_nport = rd_q.port;
			end
			dlmr_pkg::SEL_FWD: begin
				nx_action = dlmr_pkg::ActForward;
				nx_dip = succ_ip_q;
				nx_dport = succ_port_q;
				nx_kind = kind_q;
				nx_key = key_q;
				nx_nid = sid_q;
				nx_nip = sip_q;
				nx_nport = sport_q;
			end
			default: begin
				nx_action = dlmr_pkg::ActNone;
				nx_dip = '0;
				nx_dport = '0;
				nx_kind = '0;
			end
		endcase
	end

	// staging and output registers
	always_ff @(posedge clk) begin
		if (cmd.stage_load) begin
			stg_action_q <= nx_action;
			stg_dip_q <= nx_dip;
			stg_dport_q <= nx_dport;
			stg_kind_q <= nx_kind;
			stg_key_q <= nx_key;
			stg_nid_q <= nx_nid;
			stg_nip_q <= nx_nip;
			stg_nport_q <= nx_nport;
		end
		if (cmd.out_load) begin
			action <= stg_action_q;
			dest_ip <= stg_dip_q;
			dest_port <= stg_dport_q;
			out_kind <= stg_kind_q;
			out_key_id <= stg_key_q;
			out_node_id <= stg_nid_q;
			out_node_ip <= stg_nip_q;
			out_node_port <= stg_nport_q;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/dlmr_ctrl.sv =====
// ----------------------------------------------------------------------------
// dlmr_ctrl
// Controller: accepts a message, decides the route, steps the cache scan and
// hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dht_lookup_message_router_unit_assert.svh"

module dlmr_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            msg_valid,
	output logic                 msg_stall,
	output logic                 res_valid,
	input  wire logic            res_stall,
	input  wire dlmr_pkg::sts_t  sts,
	output dlmr_pkg::cmd_t       cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_READ,
		ST_CHECK,
		ST_OUT
	} state_t;

	state_t state_q, state_nx;
	logic res_valid_q;
	logic out_free;

	assign out_free = !res_valid_q || !res_stall;
	assign msg_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;

	always_comb begin
		cmd = '{default: '0, sel: dlmr_pkg::SEL_ZERO};
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				cmd.capture = msg_valid;
				if (msg_valid) begin
					state_nx = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				state_nx = ST_OUT;
				cmd.stage_load = 1'b1;
				if (sts.kind_reply) begin
					cmd.cache_wr = 1'b1;
				end else if (!sts.kind_lookup) begin
					cmd.sel = dlmr_pkg::SEL_ZERO;
				end else if (sts.own_hit) begin
					cmd.sel = dlmr_pkg::SEL_OWN;
				end else if (sts.succ_hit) begin
					cmd.sel = dlmr_pkg::SEL_SUCC;
				end else begin
					cmd.stage_load = 1'b0;
					cmd.idx_clr = 1'b1;
					state_nx = ST_READ;
				end
			end
			ST_READ: begin
				state_nx = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.cache_hit) begin
					cmd.stage_load = 1'b1;
					cmd.sel = dlmr_pkg::SEL_CACHE;
					state_nx = ST_OUT;
				end else if (sts.idx_last) begin
					cmd.stage_load = 1'b1;
					cmd.sel = dlmr_pkg::SEL_FWD;
					state_nx = ST_OUT;
				end else begin
					cmd.idx_inc = 1'b1;
					state_nx = ST_READ;
				end
			end
			ST_OUT: begin
				cmd.out_load = out_free;
				if (out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// a result never overwrites one that is still waiting
	`DLMR_ASSERT_IMP(a_out_load_free, clk, arst_n, cmd.out_load, out_free, "result overwritten")
	`DLMR_ASSERT_NXT(a_out_load_valid, clk, arst_n, cmd.out_load, res_valid_q, "result lost")
	`DLMR_ASSERT_NXT(a_accept_decide, clk, arst_n, msg_valid && !msg_stall,
		state_q == ST_DECIDE, "accepted transaction not decided")
	`DLMR_ASSERT_NXT(a_scan_end, clk, arst_n,
		(state_q == ST_CHECK) && !sts.cache_hit && sts.idx_last,
		state_q == ST_OUT, "scan overran the cache")

endmodule

`default_nettype wire

// ===== rtl/dht_lookup_message_router_unit.sv =====
// Steps: an accepted message is decided and staged, then moved to the output register
// when this node or the successor owns the key, or for a reply or ignored kind; else
// a cache scan reads, then checks, each entry in turn up to a hit or the last of 8 entries.
// Transactions: one at a time; the next is taken once the result has moved to the
// output register, which holds it on a stall.
// Reset: asynchronous, clears node registers, cache valid bits and write slot.
// ----------------------------------------------------------------------------
// dht_lookup_message_router_unit
// Ring-lookup message router with a round-robin cache of responsible nodes.
// ----------------------------------------------------------------------------
`default_nettype none

module dht_lookup_message_router_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire dlmr_pkg::cfg_idx_t             cfg_index,
	input  wire logic [dlmr_pkg::CfgDataW-1:0]  cfg_data,
	input  wire logic                           msg_valid,
	output logic                                msg_stall,
	input  wire logic [7:0]                     msg_kind,
	input  wire logic [15:0]                    key_id,
	input  wire logic [15:0]                    sender_id,
	input  wire logic [31:0]                    sender_ip,
	input  wire logic [15:0]                    sender_port,
	output logic                                res_valid,
	input  wire logic                           res_stall,
	output logic [1:0]                          action,
	output logic [31:0]                         dest_ip,
	output logic [15:0]                         dest_port,
	output logic [7:0]                          out_kind,
	output logic [15:0]                         out_key_id,
	output logic [15:0]                         out_node_id,
	output logic [31:0]                         out_node_ip,
	output logic [15:0]                         out_node_port
);

	dlmr_pkg::cmd_t cmd;
	dlmr_pkg::sts_t sts;

	dlmr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	dlmr_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.msg_kind      (msg_kind),
		.key_id        (key_id),
		.sender_id     (sender_id),
		.sender_ip     (sender_ip),
		.sender_port   (sender_port),
		.cmd           (cmd),
		.sts           (sts),
		.action        (action),
		.dest_ip       (dest_ip),
		.dest_port     (dest_port),
		.out_kind      (out_kind),
		.out_key_id    (out_key_id),
		.out_node_id   (out_node_id),
		.out_node_ip   (out_node_ip),
		.out_node_port (out_node_port)
	);

endmodule

`default_nettype wire

// ===== test/dlmr_route_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlmr_route_checker
// Watches the configuration port and both message channels of the lookup
// router, predicts the routing decision for every accepted message from its
// own copy of the node registers and responsible-node cache, and compares each
// accepted result field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------

module dlmr_route_checker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  dlmr_pkg::cfg_idx_t    cfg_index,
	input  logic [31:0]           cfg_data,
	input  logic                  msg_valid,
	input  logic                  msg_stall,
	input  logic [7:0]            msg_kind,
	input  logic [15:0]           key_id,
	input  logic [15:0]           sender_id,
	input  logic [31:0]           sender_ip,
	input  logic [15:0]           sender_port,
	input  logic                  res_valid,
	input  logic                  res_stall,
	input  logic [1:0]            action,
	input  logic [31:0]           dest_ip,
	input  logic [15:0]           dest_port,
	input  logic [7:0]            out_kind,
	input  logic [15:0]           out_key_id,
	input  logic [15:0]           out_node_id,
	input  logic [31:0]           out_node_ip,
	input  logic [15:0]           out_node_port,
	output int                    mismatches,
	output int                    awaited
);

	typedef struct packed {
		logic [7:0]  kind;
		logic [15:0] key;
		logic [15:0] node;
		logic [31:0] ip;
		logic [15:0] port;
	} ring_msg_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] dest_ip;
		logic [15:0] dest_port;
		logic [7:0]  kind;
		logic [15:0] key;
		logic [15:0] node_id;
		logic [31:0] node_ip;
		logic [15:0] hop_port;
	} route_t;

	logic [15:0] own_id_q, pred_id_q, succ_id_q, own_port_q, succ_port_q;
	logic [31:0] own_ip_q, succ_ip_q;
	dlmr_pkg::entry_t known_owners [dlmr_pkg::CacheEntries];
	int          next_slot;
	route_t      pending_routes [$];

	function automatic bit arc_holds(input logic [15:0] lo, input logic [15:0] hi,
			input logic [15:0] k);
		if (lo <= hi) begin
			return (k > lo) && (k <= hi);
		end
		return (k > lo) || (k <= hi);
	endfunction

	task automatic route_message(input ring_msg_t m);
		route_t r;
		bit     found;
		r = '0;
		if (m.kind == dlmr_pkg::KindReply) begin
			known_owners[next_slot] = '{m.key, m.node, m.ip, m.port};
			next_slot = (next_slot + 1) % dlmr_pkg::CacheEntries;
		end else if (m.kind == dlmr_pkg::KindLookup) begin
			r.action = dlmr_pkg::ActReply;
			r.dest_ip = m.ip;
			r.dest_port = m.port;
			r.kind = dlmr_pkg::KindReply;
			if ((pred_id_q == succ_id_q && own_id_q == pred_id_q) ||
					arc_holds(pred_id_q, own_id_q, m.key)) begin
				r.key = pred_id_q;
				r.node_id = own_id_q;
				r.node_ip = own_ip_q;
				r.hop_port = own_port_q;
			end else if (arc_holds(own_id_q, succ_id_q, m.key)) begin
				r.key = own_id_q;
				r.node_id = succ_id_q;
				r.node_ip = succ_ip_q;
				r.hop_port = succ_port_q;
			end else begin
				found = 1'b0;
				for (int i = 0; i < dlmr_pkg::CacheEntries && !found; i++) begin
					if (arc_holds(known_owners[i].pred, known_owners[i].owner, m.key)) begin
						found = 1'b1;
						r.key = known_owners[i].pred;
						r.node_id = known_owners[i].owner;
						r.node_ip = known_owners[i].addr;
						r.hop_port = known_owners[i].port;
					end
				end
				if (!found) begin
					r = '{dlmr_pkg::ActForward, succ_ip_q, succ_port_q, m.kind, m.key, m.node,
						m.ip, m.port};
				end
			end
		end
		pending_routes.push_back(r);
	endtask

	task automatic compare_field(input string name, input logic [31:0] exp,
			input logic [31:0] got);
		if (got !== exp) begin
			$error("%s: expected %0h, got %0h", name, exp, got);
			mismatches++;
		end
	endtask

	task automatic check_route(input route_t got);
		route_t exp;
		if (pending_routes.size() == 0) begin
			$error("result transaction with no message outstanding");
			mismatches++;
		end else begin
			exp = pending_routes.pop_front();
			compare_field("action", 32'(exp.action), 32'(got.action));
			compare_field("dest_ip", exp.dest_ip, got.dest_ip);
			compare_field("dest_port", 32'(exp.dest_port), 32'(got.dest_port));
			compare_field("out_kind", 32'(exp.kind), 32'(got.kind));
			compare_field("out_key_id", 32'(exp.key), 32'(got.key));
			compare_field("out_node_id", 32'(exp.node_id), 32'(got.node_id));
			compare_field("out_node_ip", exp.node_ip, got.node_ip);
			compare_field("out_node_port", 32'(exp.hop_port), 32'(got.hop_port));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q = '0;
			pred_id_q = '0;
			succ_id_q = '0;
			own_ip_q = '0;
			own_port_q = '0;
			succ_ip_q = '0;
			succ_port_q = '0;
			for (int i = 0; i < dlmr_pkg::CacheEntries; i++) begin
				known_owners[i] = '0;
			end
			next_slot = 0;
			pending_routes.delete();
			mismatches = 0;
			awaited <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					dlmr_pkg::RegOwnId: own_id_q = cfg_data[15:0];
					dlmr_pkg::RegPredId: pred_id_q = cfg_data[15:0];
					dlmr_pkg::RegSuccId: succ_id_q = cfg_data[15:0];
					dlmr_pkg::RegOwnIp: own_ip_q = cfg_data;
					dlmr_pkg::RegOwnPort: own_port_q = cfg_data[15:0];
					dlmr_pkg::RegSuccIp: succ_ip_q = cfg_data;
					dlmr_pkg::RegSuccPort: succ_port_q = cfg_data[15:0];
					default: ;
				endcase
			end
			if (res_valid && !res_stall) begin
				check_route('{action, dest_ip, dest_port, out_kind, out_key_id, out_node_id,
					out_node_ip, out_node_port});
			end
			if (msg_valid && !msg_stall) begin
				route_message('{msg_kind, key_id, sender_id, sender_ip, sender_port});
			end
			awaited <= pending_routes.size();
		end
	end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the lookup router with directed ring and cache cases followed by
// randomised lookups, replies and unknown kinds under several node settings
// and idling mixes, including a long consumer hold-off; a separate checker
// predicts and compares every result transaction.
// ----------------------------------------------------------------------------

module tb_top;

	localparam dlmr_pkg::cfg_idx_t RegUnused = 3'd7;
	localparam int CycleLimit = 400000;
	localparam int HoldCycles = 400;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	dlmr_pkg::cfg_idx_t cfg_index;
	logic [31:0] cfg_data;
	logic        msg_valid;
	logic        msg_stall;
	logic [7:0]  msg_kind;
	logic [15:0] key_id;
	logic [15:0] sender_id;
	logic [31:0] sender_ip;
	logic [15:0] sender_port;
	logic        res_valid;
	logic        res_stall;
	logic [1:0]  action;
	logic [31:0] dest_ip;
	logic [15:0] dest_port;
	logic [7:0]  out_kind;
	logic [15:0] out_key_id;
	logic [15:0] out_node_id;
	logic [31:0] out_node_ip;
	logic [15:0] out_node_port;
	int          mismatches;
	int          awaited;

	int          cycle_cnt = 0;
	int          idle_pct = 0;
	int          stall_pct = 0;
	logic        hold_go = 1'b0;
	int          hold_cnt = 0;
	logic [15:0] ring_own, ring_pred, ring_succ;
	logic [15:0] recent_pred [8];
	int          recent_n = 0;

	dht_lookup_message_router_unit DUT (.*);
	dlmr_route_checker route_chk (.*);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CycleLimit) begin
			$display("FAILURE");
			$finish;
		end
	end

	// consumer stalls, with one long hold-off when asked
	always @(posedge clk) begin
		if (hold_go && hold_cnt < HoldCycles) begin
			res_stall <= 1'b1;
			hold_cnt <= hold_cnt + 1;
		end else begin
			res_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
		end
	end

	task automatic put_msg(input logic [7:0] k, input logic [15:0] key, input logic [15:0] id,
			input logic [31:0] ip, input logic [15:0] prt);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			msg_valid <= 1'b0;
			@(posedge clk);
		end
		msg_valid <= 1'b1;
		msg_kind <= k;
		key_id <= key;
		sender_id <= id;
		sender_ip <= ip;
		sender_port <= prt;
		do @(posedge clk); while (msg_stall);
	endtask

	task automatic drain();
		msg_valid <= 1'b0;
		do @(posedge clk); while (awaited != 0);
	endtask

	task automatic set_reg(input dlmr_pkg::cfg_idx_t idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic set_ring(input logic [15:0] own, input logic [15:0] pred,
			input logic [15:0] succ, input logic [31:0] oip, input logic [15:0] oport,
			input logic [31:0] sip, input logic [15:0] sport);
		logic [15:0] junk;
		junk = 16'($urandom);
		set_reg(dlmr_pkg::RegOwnId, {junk, own});
		set_reg(dlmr_pkg::RegPredId, {~junk, pred});
		set_reg(dlmr_pkg::RegSuccId, {junk, succ});
		set_reg(dlmr_pkg::RegOwnIp, oip);
		set_reg(dlmr_pkg::RegOwnPort, {~junk, oport});
		set_reg(dlmr_pkg::RegSuccIp, sip);
		set_reg(dlmr_pkg::RegSuccPort, {junk, sport});
		cfg_we <= 1'b0;
		ring_own = own;
		ring_pred = pred;
		ring_succ = succ;
	endtask

	task automatic random_ring();
		logic [15:0] own;
		own = 16'($urandom);
		set_ring(own, own - 16'($urandom_range(1, 1024)), own + 16'($urandom_range(1, 1024)),
			$urandom, 16'($urandom), $urandom, 16'($urandom));
	endtask

	task automatic send_random();
		logic [15:0] key, pk, span;
		int          r;
		r = $urandom_range(99);
		if (r < 45) begin
			case ($urandom_range(4))
				0: key = 16'($urandom);
				1: key = ring_own + 16'($urandom_range(0, 8)) - 16'd4;
				2: key = ring_pred + 16'($urandom_range(0, 8)) - 16'd4;
				3: key = ring_succ + 16'($urandom_range(0, 8)) - 16'd4;
				default: key = recent_pred[$urandom_range(7)] + 16'($urandom_range(0, 512));
			endcase
			put_msg(dlmr_pkg::KindLookup, key, 16'($urandom), $urandom, 16'($urandom));
		end else if (r < 80) begin
			pk = 16'($urandom);
			span = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 6144));
			recent_pred[recent_n % 8] = pk;
			recent_n++;
			put_msg(dlmr_pkg::KindReply, pk, pk + span, $urandom, 16'($urandom));
		end else begin
			put_msg(8'($urandom_range(2, 255)), 16'($urandom), 16'($urandom), $urandom,
				16'($urandom));
		end
	endtask

	task automatic run_phase(input int n, input int idle, input int stall);
		idle_pct = idle;
		stall_pct <= stall;
		repeat (n) send_random();
		drain();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = dlmr_pkg::RegOwnId;
		cfg_data = '0;
		msg_valid = 1'b0;
		msg_kind = dlmr_pkg::KindLookup;
		key_id = '0;
		sender_id = '0;
		sender_ip = '0;
		sender_port = '0;
		res_stall = 1'b0;
		ring_own = '0;
		ring_pred = '0;
		ring_succ = '0;
		for (int i = 0; i < 8; i++) begin
			recent_pred[i] = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers at reset: single node ring of id zero owns every key
		put_msg(dlmr_pkg::KindLookup, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
		put_msg(dlmr_pkg::KindLookup, 16'hFFFF, 16'h0000, 32'h0000_0000, 16'h0000);
		put_msg(dlmr_pkg::KindReply, 16'h8000, 16'h9000, 32'hC0A8_0101, 16'd4000);
		put_msg(8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
		put_msg(8'h02, 16'h1234, 16'h5678, 32'h0A00_0001, 16'd80);
		drain();

		set_ring(16'h4000, 16'h2000, 16'h6000, 32'h0A00_0004, 16'd4004, 32'h0A00_0006,
			16'd4006);
		put_msg(dlmr_pkg::KindLookup, 16'h2000, 16'h0101, 32'h0B00_0001, 16'd1);
		put_msg(dlmr_pkg::KindLookup, 16'h2001, 16'h0102, 32'h0B00_0002, 16'd2);
		put_msg(dlmr_pkg::KindLookup, 16'h4000, 16'h0103, 32'h0B00_0003, 16'd3);
		put_msg(dlmr_pkg::KindLookup, 16'h4001, 16'h0104, 32'h0B00_0004, 16'd4);
		put_msg(dlmr_pkg::KindLookup, 16'h6000, 16'h0105, 32'h0B00_0005, 16'd5);
		put_msg(dlmr_pkg::KindLookup, 16'h8800, 16'h0106, 32'h0B00_0006, 16'd6);
		put_msg(dlmr_pkg::KindLookup, 16'h9001, 16'h0107, 32'h0B00_0007, 16'd7);
		// wrapping cache interval, then an entry that covers nothing
		put_msg(dlmr_pkg::KindReply, 16'hF000, 16'h1000, 32'hC0A8_0202, 16'd5000);
		put_msg(dlmr_pkg::KindLookup, 16'hFFFF, 16'h0108, 32'h0B00_0008, 16'd8);
		put_msg(dlmr_pkg::KindLookup, 16'h0000, 16'h0109, 32'h0B00_0009, 16'd9);
		put_msg(dlmr_pkg::KindReply, 16'h3000, 16'h3000, 32'hC0A8_0303, 16'd6000);
		put_msg(dlmr_pkg::KindLookup, 16'hB000, 16'h010A, 32'h0B00_000A, 16'd10);
		put_msg(dlmr_pkg::KindLookup, 16'h9000, 16'h010B, 32'h0B00_000B, 16'd11);
		put_msg(dlmr_pkg::KindLookup, 16'h8000, 16'h010C, 32'h0B00_000C, 16'd12);
		drain();

		// own interval wraps through zero; index seven must be ignored
		set_ring(16'h0100, 16'hF800, 16'h0800, 32'h0A00_0101, 16'd7001, 32'h0A00_0808,
			16'd7008);
		set_reg(RegUnused, 32'hDEAD_BEEF);
		cfg_we <= 1'b0;
		put_msg(dlmr_pkg::KindLookup, 16'hFFFF, 16'h0201, 32'h0C00_0001, 16'd21);
		put_msg(dlmr_pkg::KindLookup, 16'h0100, 16'h0202, 32'h0C00_0002, 16'd22);
		put_msg(dlmr_pkg::KindLookup, 16'h0500, 16'h0203, 32'h0C00_0003, 16'd23);
		put_msg(dlmr_pkg::KindLookup, 16'hF800, 16'h0204, 32'h0C00_0004, 16'd24);
		drain();

		// single node ring with a non-zero id
		set_ring(16'h1234, 16'h1234, 16'h1234, 32'h0A01_0234, 16'd1234, 32'h0A02_0234,
			16'd2234);
		put_msg(dlmr_pkg::KindLookup, 16'h5555, 16'h0301, 32'h0D00_0001, 16'd31);
		put_msg(dlmr_pkg::KindLookup, 16'h1234, 16'h0302, 32'h0D00_0002, 16'd32);
		drain();

		random_ring();
		run_phase(120, 0, 0);
		random_ring();
		run_phase(120, 72, 0);
		set_ring(16'hFFFF, 16'hFF00, 16'h0000, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF,
			16'hFFFF);
		run_phase(120, 0, 72);
		random_ring();
		run_phase(120, 26, 26);

		// long consumer hold-off so the router backs up and stalls its input
		random_ring();
		idle_pct = 0;
		stall_pct <= 0;
		hold_go <= 1'b1;
		repeat (30) send_random();
		drain();

		set_ring(16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 16'h0000, 32'h0000_0000,
			16'h0000);
		run_phase(60, 26, 26);

		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/dlmr_pkg.sv
rtl/dlmr_datapath.sv
rtl/dlmr_ctrl.sv
rtl/dht_lookup_message_router_unit.sv
test/dlmr_route_checker.sv
test/tb_top.sv
